[hw/rtl/ptp_pkg.sv]
package ptp_pkg;

    localparam int SHEET_COUNT  = 223;
    localparam int TILE_COLUMNS = 16;
    localparam int TILE_ROWS    = 4;

    localparam int ADDR_W  = 19;
    localparam int SHEET_W = (SHEET_COUNT > 1) ? $clog2(SHEET_COUNT) : 1;
    localparam int COL_W   = (TILE_COLUMNS > 1) ? $clog2(TILE_COLUMNS) : 1;
    localparam int TROW_W  = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;

    localparam int ROW_BYTES   = TILE_COLUMNS * 4;
    localparam int STRIP_BYTES = TILE_COLUMNS * 32;
    localparam int SHEET_BYTES = TILE_COLUMNS * TILE_ROWS * 32;

    localparam int STORE_DEPTH = 24;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int SIZE_2BPP   = 16;
    localparam int SIZE_3BPP   = 24;
    localparam int PLANE2_BASE = 16;

    localparam logic [0:0] REG_THREE_PLANE = 1'b0;

    typedef enum logic
    {
        ST_COLLECT,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0]
    {
        PH_PLANE0,
        PH_PLANE1,
        PH_PLANE2
    } phase_t;

    typedef struct packed
    {
        logic       valid;
        logic [2:0] row;
        logic [7:0] p0;
        logic [7:0] p1;
        logic [7:0] p2;
    } stage_t;

    function automatic logic [7:0] pack_pair(input logic [7:0] p0, input logic [7:0] p1,
                                             input logic [7:0] p2, input logic [1:0] x);
        logic [2:0] li;
        logic [2:0] ri;
        li = {~x, 1'b1};
        ri = {~x, 1'b0};
        return {1'b0, p2[li], p1[li], p0[li], 1'b0, p2[ri], p1[ri], p0[ri]};
    endfunction

endpackage

[hw/rtl/planar_tile_to_packed_pixels_core.sv]
// first result path: store read register, stage register, output registers
// emission: a row of 4 results at a time (three store reads, read register, hand-over);
//   the next row is read from the store while the row before is emitted
// throughput: one request a cycle while collecting 16 or 24 bytes; no request is taken
//   while a tile is being emitted
// reset: position, byte count and mode (three-plane) reset; tile store contents are not cleared
module planar_tile_to_packed_pixels_core
    import ptp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // tile_byte[7:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // packed_pair[7:0], out_address[26:8], zero[31:27]
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    state_t             state_reg;
    state_t             state_next;
    logic               three_plane_reg;
    logic [4:0]         count_reg;
    logic [COL_W-1:0]   col_reg;
    logic [TROW_W-1:0]  trow_reg;
    logic [SHEET_W-1:0] sheet_reg;
    logic [ADDR_W-1:0]  base_reg;
    logic [ADDR_W-1:0]  base_next;
    logic               in_accept;
    logic               complete;
    logic               start;
    logic [5:0]         size;
    logic [5:0]         count_inc;
    logic [STORE_AW-1:0] rd_addr;
    logic [7:0]         rd_data;
    stage_t             stage;
    logic               take;
    logic [7:0]         packed_pair;
    logic [ADDR_W-1:0]  out_address;
    logic               tile_done;
    logic               tile_end;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && paddr[2] == REG_THREE_PLANE;
    assign prdata    = (paddr[2] == REG_THREE_PLANE) ? {31'd0, three_plane_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            three_plane_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            three_plane_reg <= pwdata[0];
        end
    end

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign size      = three_plane_reg ? 6'(SIZE_3BPP) : 6'(SIZE_2BPP);
    assign count_inc = {1'b0, count_reg} + 6'd1;
    assign complete  = count_inc >= size;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (in_accept && complete)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (tile_end)
                begin
                    state_next = ST_COLLECT;
                end
            end
            default: state_next = ST_COLLECT;
        endcase
    end

    // outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        start         = 1'b0;
        case (state_reg)
            ST_COLLECT:
            begin
                s_axis_tready = 1'b1;
                start         = s_axis_tvalid && complete;
            end
            default:
            begin
                s_axis_tready = 1'b0;
                start         = 1'b0;
            end
        endcase
    end

    assign base_next = ADDR_W'(int'(sheet_reg) * SHEET_BYTES + int'(trow_reg) * STRIP_BYTES
                               + int'(col_reg) * 4);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
            count_reg <= '0;
            col_reg   <= '0;
            trow_reg  <= '0;
            sheet_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_accept)
            begin
                count_reg <= complete ? 5'd0 : count_inc[4:0];
            end
            if (tile_end)
            begin
                if (col_reg == COL_W'(TILE_COLUMNS - 1))
                begin
                    col_reg <= '0;
                    if (trow_reg == TROW_W'(TILE_ROWS - 1))
                    begin
                        trow_reg  <= '0;
                        sheet_reg <= (sheet_reg == SHEET_W'(SHEET_COUNT - 1)) ? '0
                                     : sheet_reg + SHEET_W'(1);
                    end
                    else
                    begin
                        trow_reg <= trow_reg + TROW_W'(1);
                    end
                end
                else
                begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            base_reg <= base_next;
        end
    end

    ptp_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (in_accept && count_reg < 5'(STORE_DEPTH)),
        .waddr (count_reg[STORE_AW-1:0]),
        .wdata (s_axis_tdata),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    ptp_fetch u_fetch (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .three_plane (three_plane_reg),
        .rd_data     (rd_data),
        .rd_addr     (rd_addr),
        .stage       (stage),
        .take        (take)
    );

    ptp_pair_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage       (stage),
        .take        (take),
        .tile_base   (base_reg),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .packed_pair (packed_pair),
        .out_address (out_address),
        .tile_done   (tile_done),
        .tile_end    (tile_end)
    );

    assign m_axis_tdata = {5'd0, out_address, packed_pair};
    assign m_axis_tlast = tile_done;

    // results appear only while a tile is being emitted
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> state_reg == ST_EMIT)
        else $error("result outside emission");

    // the byte count never runs past the tile store
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < 5'(STORE_DEPTH))
        else $error("byte count overflow");

    // a completing request starts emission with the count cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        start |=> state_reg == ST_EMIT && count_reg == 5'd0)
        else $error("tile completion not followed by emission");

    // a waiting row is never overwritten by the next row's reads
    assert property (@(posedge clk) disable iff (!rst_n)
        stage.valid && !take |=> stage.valid && $stable(stage.row))
        else $error("staged row lost");

endmodule

[hw/rtl/ptp_ram.sv]
module ptp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 24
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/ptp_fetch.sv]
module ptp_fetch
    import ptp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                three_plane,
    input  logic [7:0]          rd_data,
    output logic [STORE_AW-1:0] rd_addr,
    output stage_t              stage,
    input  logic                take
);

    logic [3:0]  row_reg;
    logic [3:0]  row_next;
    phase_t      phase_reg;
    phase_t      phase_next;
    logic        pend_reg;
    phase_t      pend_phase_reg;
    logic [2:0]  pend_row_reg;
    stage_t      stage_reg;
    stage_t      stage_next;
    logic        issue;

    // one row is three reads; hold off after the eighth row, while a full row waits or while its last read is in flight
    assign issue = !row_reg[3] && !stage_reg.valid &&
                   !(pend_reg && pend_phase_reg == PH_PLANE2);

    always_comb
    begin
        rd_addr = '0;
        case (phase_reg)
            PH_PLANE0: rd_addr = STORE_AW'({row_reg[2:0], 1'b0});
            PH_PLANE1: rd_addr = STORE_AW'({row_reg[2:0], 1'b1});
            PH_PLANE2: rd_addr = STORE_AW'(PLANE2_BASE) + STORE_AW'(row_reg[2:0]);
            default:   rd_addr = '0;
        endcase
    end

    always_comb
    begin
        row_next   = row_reg;
        phase_next = phase_reg;
        if (start)
        begin
            row_next   = '0;
            phase_next = PH_PLANE0;
        end
        else if (issue)
        begin
            case (phase_reg)
                PH_PLANE0: phase_next = PH_PLANE1;
                PH_PLANE1: phase_next = PH_PLANE2;
                default:
                begin
                    phase_next = PH_PLANE0;
                    row_next   = row_reg + 4'd1;
                end
            endcase
        end
    end

    always_comb
    begin
        stage_next = stage_reg;
        if (take)
        begin
            stage_next.valid = 1'b0;
        end
        if (pend_reg)
        begin
            case (pend_phase_reg)
                PH_PLANE0: stage_next.p0 = rd_data;
                PH_PLANE1: stage_next.p1 = rd_data;
                PH_PLANE2:
                begin
                    stage_next.p2    = three_plane ? rd_data : 8'd0;
                    stage_next.row   = pend_row_reg;
                    stage_next.valid = 1'b1;
                end
                default: stage_next = stage_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg         <= 4'd8;
            phase_reg       <= PH_PLANE0;
            pend_reg        <= 1'b0;
            pend_phase_reg  <= PH_PLANE0;
            stage_reg       <= '0;
        end
        else
        begin
            row_reg         <= row_next;
            phase_reg       <= phase_next;
            pend_reg        <= issue && !start;
            pend_phase_reg  <= phase_reg;
            stage_reg       <= stage_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_row_reg   <= row_reg[2:0];
    end

    assign stage = stage_reg;

endmodule

[hw/rtl/ptp_pair_out.sv]
module ptp_pair_out
    import ptp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  stage_t            stage,
    output logic              take,
    input  logic [ADDR_W-1:0] tile_base,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        packed_pair,
    output logic [ADDR_W-1:0] out_address,
    output logic              tile_done,
    output logic              tile_end
);

    logic              busy_reg;
    logic [1:0]        pair_reg;
    logic [2:0]        row_reg;
    logic [7:0]        p0_reg;
    logic [7:0]        p1_reg;
    logic [7:0]        p2_reg;
    logic              accept;
    logic              row_end;
    logic [ADDR_W-1:0] offset;

    assign accept  = busy_reg && out_ready;
    assign row_end = accept && pair_reg == 2'd3;
    assign take    = stage.valid && (!busy_reg || row_end);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pair_reg <= '0;
        end
        else if (take)
        begin
            busy_reg <= 1'b1;
            pair_reg <= '0;
        end
        else if (accept)
        begin
            pair_reg <= pair_reg + 2'd1;
            if (row_end)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            row_reg <= stage.row;
            p0_reg  <= stage.p0;
            p1_reg  <= stage.p1;
            p2_reg  <= stage.p2;
        end
    end

    assign offset      = ADDR_W'(int'(row_reg) * ROW_BYTES + int'(pair_reg));
    assign out_valid   = busy_reg;
    assign packed_pair = pack_pair(p0_reg, p1_reg, p2_reg, pair_reg);
    assign out_address = tile_base + offset;
    assign tile_done   = busy_reg && row_reg == 3'd7 && pair_reg == 2'd3;
    assign tile_end    = accept && tile_done;

endmodule

[sim/packed_pixel_checker.sv]
`timescale 1ns / 1ps
module packed_pixel_checker
    import ptp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // tile_byte[7:0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // packed_pair[7:0], out_address[26:8], zero[31:27]
    input  logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending
);

    localparam logic [2:0] MODE_ADDR  = {REG_THREE_PLANE, 2'b00};

    typedef struct packed
    {
        logic [7:0]        pair;
        logic [ADDR_W-1:0] addr;
        logic              done;
    } pixel_pair_t;

    pixel_pair_t expected_pairs[$];
    logic [7:0]  plane_bytes [STORE_DEPTH];
    int          bytes_held;
    int          tile_col;
    int          tile_strip;
    int          sheet;
    logic        three_plane;

    task automatic flag(input string field, input int unsigned want, input int unsigned got);
        fail_count++;
        $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
    endtask

    // queue the 32 packed pairs of the buffered tile, then step the raster position
    task automatic convert_tile();
        int          base;
        logic [7:0]  p0;
        logic [7:0]  p1;
        logic [7:0]  p2;
        pixel_pair_t entry;
        base = sheet * SHEET_BYTES + tile_strip * STRIP_BYTES + tile_col * 4;
        for (int y = 0; y < 8; y++)
        begin
            p0 = plane_bytes[2 * y];
            p1 = plane_bytes[2 * y + 1];
            p2 = three_plane ? plane_bytes[PLANE2_BASE + y] : 8'h00;
            for (int x = 0; x < 4; x++)
            begin
                entry.pair = {1'b0, p2[7 - 2 * x], p1[7 - 2 * x], p0[7 - 2 * x],
                              1'b0, p2[6 - 2 * x], p1[6 - 2 * x], p0[6 - 2 * x]};
                entry.addr = ADDR_W'(base + y * ROW_BYTES + x);
                entry.done = (y == 7) && (x == 3);
                expected_pairs.push_back(entry);
            end
        end
        bytes_held = 0;
        tile_col++;
        if (tile_col >= TILE_COLUMNS)
        begin
            tile_col = 0;
            tile_strip++;
            if (tile_strip >= TILE_ROWS)
            begin
                tile_strip = 0;
                sheet++;
                if (sheet >= SHEET_COUNT)
                    sheet = 0;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_pair_t want;
        if (!rst_n)
        begin
            expected_pairs.delete();
            bytes_held  = 0;
            tile_col    = 0;
            tile_strip  = 0;
            sheet       = 0;
            three_plane = 1'b1;
            fail_count  = 0;
            pending     = 0;
        end
        else
        begin
            if (psel && penable && pready && paddr == MODE_ADDR)
            begin
                if (pwrite)
                    three_plane = pwdata[0];
                else if (prdata != {31'b0, three_plane})
                    flag("three_plane_mode readback", {31'b0, three_plane}, prdata);
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (bytes_held < STORE_DEPTH)
                    plane_bytes[bytes_held] = s_axis_tdata;
                bytes_held++;
                if (bytes_held >= (three_plane ? SIZE_3BPP : SIZE_2BPP))
                    convert_tile();
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_pairs.size() == 0)
                    flag("unexpected request out_address", 0, m_axis_tdata[26:8]);
                else
                begin
                    want = expected_pairs.pop_front();
                    if (m_axis_tdata[7:0] != want.pair)
                        flag("packed_pair", want.pair, m_axis_tdata[7:0]);
                    if (m_axis_tdata[26:8] != want.addr)
                        flag("out_address", want.addr, m_axis_tdata[26:8]);
                    if (m_axis_tlast != want.done)
                        flag("tile_done", want.done, m_axis_tlast);
                end
            end
            pending = expected_pairs.size();
        end
    end

endmodule

[sim/planar_tile_to_packed_pixels_core_test.sv]
`timescale 1ns / 1ps
module planar_tile_to_packed_pixels_core_test;
    import ptp_pkg::*;

    localparam int         HALF_PERIOD   = 2;
    localparam int         RESET_CYCLES  = 11;
    localparam int         SETTLE_CYCLES = 12;
    localparam int         TAIL_CYCLES   = 60;
    localparam int         HOLD_CYCLES   = 400;
    localparam int         RANDOM_BYTES  = 100;
    localparam int         CLOSING_BYTES = 2 * SIZE_2BPP;
    localparam int         TIMEOUT_NS    = 20_000_000;
    localparam logic [2:0] MODE_ADDR     = {REG_THREE_PLANE, 2'b00};
    localparam logic [2:0] SPARE_ADDR    = MODE_ADDR + 3'd4;
    // one three-plane tile, first byte in the low bits: pixel values 0, 1, 2, 5, 6 and 7 appear
    localparam logic [191:0] EDGE_TILE =
        192'h8001f00f_55aa00ff_80010180_aa5555aa_ff0000ff_0000ffff;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;

    logic three_plane;
    int   fill;
    int   tiles_sent;
    bit   tx_gaps;
    bit   rx_stalls;
    bit   hold_pending;

    planar_tile_to_packed_pixels_core dut (.*);

    packed_pixel_checker pixel_check (.*);

    always #HALF_PERIOD clk = ~clk;

    task automatic send_byte(input logic [7:0] value);
        if (tx_gaps && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        fill++;
        if (fill >= (three_plane ? SIZE_3BPP : SIZE_2BPP))
        begin
            fill = 0;
            tiles_sent++;
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic apb_access(input logic is_write, input logic [2:0] addr,
                              input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_mode(input logic mode);
        apb_access(1'b1, MODE_ADDR, ($urandom() & 32'hffff_fffe) | {31'b0, mode});
        apb_access(1'b0, MODE_ADDR, 32'h0);
        three_plane = mode;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // receiver: random stalls, plus one long hold-off on demand
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                m_axis_tready <= 1'b1;
            end
            else if (rx_stalls && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int sent;
        int segment;
        int run;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = 3'd0;
        pwdata        = 32'h0;
        three_plane   = 1'b1;
        fill          = 0;
        tiles_sent    = 0;
        tx_gaps       = 1'b0;
        rx_stalls     = 1'b0;
        hold_pending  = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset mode readback, then a full three-plane tile of edge patterns
        apb_access(1'b0, MODE_ADDR, 32'h0);
        for (int i = 0; i < SIZE_3BPP; i++)
            send_byte(EDGE_TILE[8 * i +: 8]);
        wait_drained();

        // switch to two planes with 20 bytes already held: next byte closes the tile
        for (int i = 0; i < 20; i++)
            send_byte(pick_byte());
        wait_drained();
        set_mode(1'b0);
        send_byte(8'hff);
        wait_drained();

        // spare register address must not touch the mode
        apb_access(1'b1, SPARE_ADDR, 32'hffff_ffff);
        apb_access(1'b0, MODE_ADDR, 32'h0);

        sent    = 0;
        segment = 0;
        while (sent < RANDOM_BYTES)
        begin
            tx_gaps   = $urandom_range(0, 3) != 0;
            rx_stalls = $urandom_range(0, 3) != 0;
            run       = $urandom_range(1, 30);
            if (segment == 2)
            begin
                hold_pending = 1'b1;
                tx_gaps      = 1'b0;
                run          = 40;
            end
            else if (segment == 1 || $urandom_range(0, 3) == 0)
            begin
                wait_drained();
                set_mode(segment == 1 ? 1'b1 : ~three_plane);
            end
            repeat (run)
            begin
                send_byte(pick_byte());
                sent++;
            end
            segment++;
        end

        // closing stretch without idling
        wait_drained();
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        set_mode(1'b0);
        repeat (CLOSING_BYTES)
            send_byte(8'($urandom_range(0, 255)));
        s_axis_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
